[hdl/rmth_pkg.sv]
// rmth_pkg: shared widths and heap select codes for the running median core
// no dependencies
package rmth_pkg;

  // result field widths, fixed by the interface
  localparam int unsigned MedianW = 33;
  localparam int unsigned CountW  = 11;

  // heap select codes
  localparam logic HeapLower = 1'b0;
  localparam logic HeapUpper = 1'b1;

endpackage

[hdl/rmth_ram.sv]
// rmth_ram: generic single write port, single read port ram, registered read
// no dependencies
module rmth_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/running_median_two_heaps_core.sv]
// running median over two heaps: max-heap of the lower half, min-heap of the upper half
// a dropped request passes the plan, next and output states only; otherwise up to
//   three heap passes, each level of sift-up taking a read and a compare state and each
//   level of sift-down a left read, right read, compare and write state; one request in
//   flight at a time, set by the single read port of each heap memory
// reset clears the heap counts and the control state; heap memories need no clearing pass
// depends on rmth_pkg and rmth_ram
module running_median_two_heaps_core #(
  parameter int unsigned HEAP_DEPTH  = 512,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          sample_valid_i,
  output logic                          sample_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          result_valid_o,
  input  logic                          result_stall_i,
  output logic signed [rmth_pkg::MedianW-1:0] median_doubled_o,
  output logic [rmth_pkg::CountW-1:0]   sample_count_o,
  output logic                          dropped_o
);
  import rmth_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned SB = SAMPLE_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PLAN = 4'd1;
  localparam logic [3:0] S_NEXT = 4'd2;
  localparam logic [3:0] S_PU_S = 4'd3;
  localparam logic [3:0] S_PU_R = 4'd4;
  localparam logic [3:0] S_PU_C = 4'd5;
  localparam logic [3:0] S_SD_L = 4'd6;
  localparam logic [3:0] S_SD_R = 4'd7;
  localparam logic [3:0] S_SD_C = 4'd8;
  localparam logic [3:0] S_SD_W = 4'd9;
  localparam logic [3:0] S_POP  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  // true if a belongs above b: lower heap is a max-heap, upper a min-heap
  function automatic logic ahead(logic signed [SB-1:0] a, logic signed [SB-1:0] b,
                                 logic h);
    ahead = (h == HeapUpper) ? (a < b) : (a > b);
  endfunction

  logic [3:0]           state_q;
  logic [CW-1:0]        cnt_q [2];
  logic signed [SB-1:0] top_q [2];
  logic signed [SB-1:0] s_q;
  logic                 dropped_q;
  logic                 op_h_q;
  logic signed [SB-1:0] val_q;
  logic [AW-1:0]        idx_q;
  logic [CW-1:0]        n_q;
  logic signed [SB-1:0] best_v_q;
  logic [AW-1:0]        best_i_q;
  logic                 push_pend_q, push_h_q;
  logic signed [SB-1:0] push_v_q;
  logic                 repl_pend_q, repl_h_q;
  logic                 out_valid_q;
  logic signed [MedianW-1:0] med_q;
  logic [CountW-1:0]    count_q;
  logic                 drop_out_q;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic signed [SB-1:0] wr_data;
  logic [SB-1:0]        rd_l, rd_u;
  logic signed [SB-1:0] rdata;
  logic [CW:0]          l_w, r_w;
  logic [AW-1:0]        parent;
  logic                 bal_lo, bal_up, pop_h;
  logic [CW-1:0]        pop_n;
  logic                 lf, uf;
  logic signed [SB:0]   med_w;

  assign lf     = cnt_q[0] >= CW'(HEAP_DEPTH);
  assign uf     = cnt_q[1] >= CW'(HEAP_DEPTH);
  assign l_w    = (CW + 1)'({idx_q, 1'b0}) + (CW + 1)'(1);
  assign r_w    = l_w + (CW + 1)'(1);
  assign parent = (idx_q - AW'(1)) >> 1;
  assign bal_lo = (CW + 1)'(cnt_q[0]) > (CW + 1)'(cnt_q[1]) + (CW + 1)'(1);
  assign bal_up = (CW + 1)'(cnt_q[0]) + (CW + 1)'(1) < (CW + 1)'(cnt_q[1]);
  assign pop_h  = bal_lo ? HeapLower : HeapUpper;
  assign pop_n  = cnt_q[pop_h] - CW'(1);
  assign rdata  = (op_h_q == HeapUpper) ? $signed(rd_u) : $signed(rd_l);

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = val_q;
    rd_addr = idx_q;
    case (state_q)
      S_PU_R: begin
        if (idx_q == '0) wr_en = 1'b1;
        else rd_addr = parent;
      end
      S_PU_C: begin
        wr_en = 1'b1;
        if (ahead(val_q, rdata, op_h_q)) wr_data = rdata;
      end
      S_SD_L: begin
        if (l_w >= (CW + 1)'(n_q)) wr_en = 1'b1;
        else rd_addr = l_w[AW-1:0];
      end
      S_SD_R: rd_addr = r_w[AW-1:0];
      S_SD_W: begin
        wr_en = 1'b1;
        if (best_i_q != idx_q) wr_data = best_v_q;
      end
      S_NEXT: rd_addr = pop_n[AW-1:0];
      default: ;
    endcase
  end

  rmth_ram #(.Width(SB), .Depth(HEAP_DEPTH)) u_lower_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en && (op_h_q == HeapLower)),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_l)
  );

  rmth_ram #(.Width(SB), .Depth(HEAP_DEPTH)) u_upper_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en && (op_h_q == HeapUpper)),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_u)
  );

  // median from the two tops
  always_comb begin
    if (cnt_q[0] == cnt_q[1]) begin
      med_w = (cnt_q[0] != '0) ? ((SB + 1)'(top_q[0]) + (SB + 1)'(top_q[1])) : '0;
    end else if (cnt_q[0] > cnt_q[1]) begin
      med_w = (SB + 1)'(top_q[0]) <<< 1;
    end else begin
      med_w = (SB + 1)'(top_q[1]) <<< 1;
    end
  end

  // top copies follow every write of a heap root
  always_ff @(posedge clk_i) begin
    if (wr_en && wr_addr == '0) begin
      top_q[op_h_q] <= wr_data;
    end
  end

  // request sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      push_pend_q <= 1'b0;
      repl_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !result_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (sample_valid_i) begin
            s_q     <= sample_i;
            state_q <= S_PLAN;
          end
        end
        S_PLAN: begin
          dropped_q <= lf && uf;
          state_q   <= S_NEXT;
          if (lf && uf) begin
            // both heaps full: stores stay as they are
          end else if (cnt_q[0] == '0 || top_q[0] > s_q) begin
            push_pend_q <= 1'b1;
            if (lf) begin
              push_h_q    <= HeapUpper;
              push_v_q    <= top_q[0];
              repl_pend_q <= 1'b1;
              repl_h_q    <= HeapLower;
            end else begin
              push_h_q <= HeapLower;
              push_v_q <= s_q;
            end
          end else begin
            push_pend_q <= 1'b1;
            if (uf) begin
              push_h_q <= HeapLower;
              if (s_q <= top_q[1]) begin
                push_v_q <= s_q;
              end else begin
                push_v_q    <= top_q[1];
                repl_pend_q <= 1'b1;
                repl_h_q    <= HeapUpper;
              end
            end else begin
              push_h_q <= HeapUpper;
              push_v_q <= s_q;
            end
          end
        end
        S_NEXT: begin
          if (repl_pend_q) begin
            repl_pend_q <= 1'b0;
            op_h_q      <= repl_h_q;
            val_q       <= s_q;
            idx_q       <= '0;
            n_q         <= cnt_q[repl_h_q];
            state_q     <= S_SD_L;
          end else if (push_pend_q) begin
            push_pend_q <= 1'b0;
            op_h_q      <= push_h_q;
            val_q       <= push_v_q;
            state_q     <= S_PU_S;
          end else if (bal_lo || bal_up) begin
            cnt_q[pop_h] <= pop_n;
            op_h_q       <= pop_h;
            push_pend_q  <= 1'b1;
            push_h_q     <= ~pop_h;
            push_v_q     <= top_q[pop_h];
            state_q      <= S_POP;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_PU_S: begin
          idx_q          <= cnt_q[op_h_q][AW-1:0];
          cnt_q[op_h_q]  <= cnt_q[op_h_q] + CW'(1);
          state_q        <= S_PU_R;
        end
        S_PU_R: begin
          state_q <= (idx_q == '0) ? S_NEXT : S_PU_C;
        end
        S_PU_C: begin
          if (ahead(val_q, rdata, op_h_q)) begin
            idx_q   <= parent;
            state_q <= S_PU_R;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_SD_L: begin
          state_q <= (l_w >= (CW + 1)'(n_q)) ? S_NEXT : S_SD_R;
        end
        S_SD_R: begin
          if (ahead(rdata, val_q, op_h_q)) begin
            best_v_q <= rdata;
            best_i_q <= l_w[AW-1:0];
          end else begin
            best_v_q <= val_q;
            best_i_q <= idx_q;
          end
          state_q <= (r_w < (CW + 1)'(n_q)) ? S_SD_C : S_SD_W;
        end
        S_SD_C: begin
          if (ahead(rdata, best_v_q, op_h_q)) begin
            best_v_q <= rdata;
            best_i_q <= r_w[AW-1:0];
          end
          state_q <= S_SD_W;
        end
        S_SD_W: begin
          if (best_i_q == idx_q) begin
            state_q <= S_NEXT;
          end else begin
            idx_q   <= best_i_q;
            state_q <= S_SD_L;
          end
        end
        S_POP: begin
          if (cnt_q[op_h_q] != '0) begin
            val_q   <= rdata;
            idx_q   <= '0;
            n_q     <= cnt_q[op_h_q];
            state_q <= S_SD_L;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || !result_stall_i) begin
            out_valid_q <= 1'b1;
            med_q       <= MedianW'(med_w);
            count_q     <= CountW'((CW + 1)'(cnt_q[0]) + (CW + 1)'(cnt_q[1]));
            drop_out_q  <= dropped_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign sample_stall_o   = (state_q != S_IDLE);
  assign result_valid_o   = out_valid_q;
  assign median_doubled_o = med_q;
  assign sample_count_o   = count_q;
  assign dropped_o        = drop_out_q;

`ifndef ASSERT_OFF
  // heap sizes stay balanced between requests
  a_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((CW + 1)'(cnt_q[0]) <= (CW + 1)'(cnt_q[1]) + (CW + 1)'(1) &&
                             (CW + 1)'(cnt_q[1]) <= (CW + 1)'(cnt_q[0]) + (CW + 1)'(1)))
    else $error("heap sizes out of balance");

  // no heap grows past its depth
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CW'(HEAP_DEPTH)) && (cnt_q[1] <= CW'(HEAP_DEPTH)))
    else $error("heap count past depth");

  // writes stay inside the live part of a heap
  a_wr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (CW'(wr_addr) < cnt_q[op_h_q]))
    else $error("write beyond heap count");

  // a drop only happens with both heaps full
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLAN) ##1 dropped_q |-> (lf && uf))
    else $error("drop with room left");
`endif

endmodule

[bench/running_median_two_heaps_core_tb.sv]
// running_median_two_heaps_core_tb: checks the running median core against an in-bench model
// of the two heaps, with random idling on both handshakes; depends on rmth_pkg and the core
module running_median_two_heaps_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 512;
  localparam int unsigned SampleW = 32;
  localparam longint CycleLimit = 2000000;

  typedef struct packed {
    logic signed [rmth_pkg::MedianW-1:0] median_doubled;
    logic [rmth_pkg::CountW-1:0] sample_count;
    logic dropped;
  } median_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic sample_valid_i = 1'b0;
  logic signed [SampleW-1:0] sample_i = '0;
  logic result_stall_i = 1'b0;
  logic sample_stall_o, result_valid_o, dropped_o;
  logic signed [rmth_pkg::MedianW-1:0] median_doubled_o;
  logic [rmth_pkg::CountW-1:0] sample_count_o;

  running_median_two_heaps_core #(.HEAP_DEPTH(Depth), .SAMPLE_BITS(SampleW)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .sample_valid_i(sample_valid_i), .sample_stall_o(sample_stall_o), .sample_i(sample_i),
    .result_valid_o(result_valid_o), .result_stall_i(result_stall_i),
    .median_doubled_o(median_doubled_o), .sample_count_o(sample_count_o),
    .dropped_o(dropped_o)
  );

  always #1 clk_i = ~clk_i;

  // model state: max-heap of the lower half, min-heap of the upper half
  longint lo_heap[Depth];
  longint hi_heap[Depth];
  int unsigned lo_n, hi_n;
  median_res_t median_q[$];
  int unsigned fail_cnt;
  longint cycle_cnt;
  bit quiet;            // no idling on either side
  int idle_pct = 19;

  function automatic bit ranks_above(longint a, longint b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic heap_sift_down(ref longint h[Depth], input int unsigned n, input bit is_max);
    int unsigned i, l, r, best;
    longint t;
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      best = i;
      if (l < n && ranks_above(h[l], h[best], is_max)) best = l;
      if (r < n && ranks_above(h[r], h[best], is_max)) best = r;
      if (best == i) break;
      t = h[i]; h[i] = h[best]; h[best] = t;
      i = best;
    end
  endtask

  task automatic heap_insert(ref longint h[Depth], ref int unsigned n, input longint v,
                             input bit is_max);
    int unsigned i, p;
    longint t;
    i = n;
    if (i >= Depth) return;
    h[i] = v;
    n = i + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks_above(h[i], h[p], is_max)) break;
      t = h[i]; h[i] = h[p]; h[p] = t;
      i = p;
    end
  endtask

  task automatic heap_take_top(ref longint h[Depth], ref int unsigned n, input bit is_max,
                               output longint top);
    top = h[0];
    if (n == 0) begin
      top = 0;
      return;
    end
    n = n - 1;
    h[0] = h[n];
    heap_sift_down(h, n, is_max);
  endtask

  task automatic heap_swap_top(ref longint h[Depth], input int unsigned n, input longint v,
                               input bit is_max);
    if (n == 0) return;
    h[0] = v;
    heap_sift_down(h, n, is_max);
  endtask

  // insert one sample, rebalance and work out the median
  task automatic median_update(input logic signed [SampleW-1:0] smp, output median_res_t res);
    longint s, v, med;
    bit drop;
    s = longint'(smp);
    drop = 1'b0;
    med = 0;
    if (lo_n >= Depth && hi_n >= Depth) begin
      drop = 1'b1;
    end else if (lo_n == 0 || lo_heap[0] > s) begin
      if (lo_n >= Depth) begin
        heap_insert(hi_heap, hi_n, lo_heap[0], 1'b0);
        heap_swap_top(lo_heap, lo_n, s, 1'b1);
      end else begin
        heap_insert(lo_heap, lo_n, s, 1'b1);
      end
    end else begin
      if (hi_n >= Depth) begin
        if (s <= hi_heap[0]) begin
          heap_insert(lo_heap, lo_n, s, 1'b1);
        end else begin
          heap_insert(lo_heap, lo_n, hi_heap[0], 1'b1);
          heap_swap_top(hi_heap, hi_n, s, 1'b0);
        end
      end else begin
        heap_insert(hi_heap, hi_n, s, 1'b0);
      end
    end
    // keep the sizes within one
    if (lo_n > hi_n + 1) begin
      heap_take_top(lo_heap, lo_n, 1'b1, v);
      heap_insert(hi_heap, hi_n, v, 1'b0);
    end else if (lo_n + 1 < hi_n) begin
      heap_take_top(hi_heap, hi_n, 1'b0, v);
      heap_insert(lo_heap, lo_n, v, 1'b1);
    end
    if (lo_n == hi_n) begin
      if (lo_n != 0) med = lo_heap[0] + hi_heap[0];
    end else if (lo_n > hi_n) begin
      med = lo_heap[0] * 2;
    end else begin
      med = hi_heap[0] * 2;
    end
    res.median_doubled = med[rmth_pkg::MedianW-1:0];
    res.sample_count = rmth_pkg::CountW'(lo_n + hi_n);
    res.dropped = drop;
  endtask

  // send one request, predicting its result at acceptance
  task automatic send_sample(input logic signed [SampleW-1:0] smp);
    median_res_t res;
    while (!quiet && $urandom_range(99) < idle_pct) begin
      sample_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i <= smp;
    @(posedge clk_i);
    while (sample_stall_o) @(posedge clk_i);
    median_update(smp, res);
    median_q.push_back(res);
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    median_res_t exp_r;
    if (rst_ni) begin
      if (result_valid_o && !result_stall_i) begin
        if (median_q.size() == 0) begin
          $display("%0t: unexpected result median %0d count %0d dropped %0b", $time,
                   median_doubled_o, sample_count_o, dropped_o);
          fail_cnt++;
        end else begin
          exp_r = median_q.pop_front();
          if (median_doubled_o !== exp_r.median_doubled) begin
            $display("%0t: median_doubled expected %0d actual %0d", $time,
                     exp_r.median_doubled, median_doubled_o);
            fail_cnt++;
          end
          if (sample_count_o !== exp_r.sample_count) begin
            $display("%0t: sample_count expected %0d actual %0d", $time,
                     exp_r.sample_count, sample_count_o);
            fail_cnt++;
          end
          if (dropped_o !== exp_r.dropped) begin
            $display("%0t: dropped expected %0b actual %0b", $time, exp_r.dropped, dropped_o);
            fail_cnt++;
          end
        end
      end
      result_stall_i <= !quiet && ($urandom_range(99) < idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL running_median_two_heaps_core");
      $finish;
    end
  end

  task automatic wait_drained();
    sample_valid_i <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
  endtask

  // extremes, first sample into an empty set, equal samples
  task automatic test_directed();
    send_sample(32'sh7fffffff);
    send_sample(-32'sh80000000);
    send_sample(32'sh7fffffff);
    send_sample(-32'sh80000000);
    send_sample(0);
    send_sample(0);
    send_sample(0);
    send_sample(-1);
    send_sample(1);
    send_sample(32'sh55555555);
    send_sample(32'shaaaaaaaa);
    send_sample(32'sh7ffffffe);
    send_sample(-32'sh7fffffff);
    wait_drained();
  endtask

  // random samples: mostly narrow values to get many duplicates, some full range
  task automatic test_random(input int unsigned n);
    logic signed [SampleW-1:0] s;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: s = $urandom;
        1: s = $signed($urandom_range(40)) - 20;
        default: s = $signed($urandom_range(2000)) - 1000;
      endcase
      send_sample(s);
    end
  endtask

  // run past capacity: fill both heaps, then drops with all kinds of samples
  task automatic test_overflow();
    test_random(1100 - (lo_n + hi_n));
    wait_drained();
    test_random(840);
    send_sample(32'sh7fffffff);
    send_sample(-32'sh80000000);
  endtask

  initial begin
    fail_cnt = 0;
    cycle_cnt = 0;
    lo_n = 0;
    hi_n = 0;
    quiet = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500);
    quiet = 1'b1;
    test_random(300);
    quiet = 1'b0;
    test_overflow();
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && median_q.size() == 0) begin
      $display("PASS running_median_two_heaps_core");
    end else begin
      $display("FAIL running_median_two_heaps_core");
    end
    $finish;
  end
endmodule
